// ----- sv/bie_pkg.sv -----
// Shared types, codes and constants of the brainfuck instruction engine.
package bie_pkg;

   localparam int OP_WIDTH     = 2;
   localparam int ADDR_WIDTH   = 10;
   localparam int BYTE_WIDTH   = 8;
   localparam int STATUS_WIDTH = 2;

   localparam int DEF_PROGRAM_DEPTH = 1024;
   localparam int DEF_TAPE_DEPTH    = 1024;
   localparam int DEF_STACK_DEPTH   = 256;

   // Item operations.
   localparam logic [OP_WIDTH-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_START = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_STEP  = 2'd2;

   // Run status codes.
   localparam logic [STATUS_WIDTH-1:0] STAT_RUN       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_END       = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_OVERFLOW  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STAT_UNMATCHED = 2'd3;

   // Program command characters.
   localparam logic [BYTE_WIDTH-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_WIDTH-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_WIDTH-1:0] CH_DOT   = 8'h2E;
   localparam logic [BYTE_WIDTH-1:0] CH_LT    = 8'h3C;
   localparam logic [BYTE_WIDTH-1:0] CH_GT    = 8'h3E;
   localparam logic [BYTE_WIDTH-1:0] CH_LBR   = 8'h5B;
   localparam logic [BYTE_WIDTH-1:0] CH_RBR   = 8'h5D;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   operation;
      logic [ADDR_WIDTH-1:0] address;
      logic [BYTE_WIDTH-1:0] data;
   } req_item_type;

   typedef struct packed {
      logic                    char_valid;
      logic [BYTE_WIDTH-1:0]   char_out;
      logic [STATUS_WIDTH-1:0] status;
      logic [ADDR_WIDTH-1:0]   program_counter;
   } rsp_item_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_EXEC
   } fsm_state_type;

endpackage

// ----- sv/bie_ram.sv -----
// Simple dual-port synchronous RAM with one write port and a registered read port.
module bie_ram #(
   parameter int DEPTH = bie_pkg::DEF_PROGRAM_DEPTH,
   parameter int WIDTH = bie_pkg::BYTE_WIDTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   import bie_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/bie_engine.sv -----
// Sequencer and datapath: fetch, execute and write back one instruction per step item.
module bie_engine #(
   parameter int PROGRAM_DEPTH = bie_pkg::DEF_PROGRAM_DEPTH,
   parameter int TAPE_DEPTH    = bie_pkg::DEF_TAPE_DEPTH,
   parameter int STACK_DEPTH   = bie_pkg::DEF_STACK_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  bie_pkg::req_item_type            req_item,
   output logic                             rsp_valid,
   output bie_pkg::rsp_item_type            rsp_item,
   output logic                             prog_we,
   output logic [$clog2(PROGRAM_DEPTH)-1:0] prog_waddr,
   output logic [bie_pkg::BYTE_WIDTH-1:0]   prog_wdata,
   output logic                             prog_re,
   output logic [$clog2(PROGRAM_DEPTH)-1:0] prog_raddr,
   input  logic [bie_pkg::BYTE_WIDTH-1:0]   prog_rdata,
   output logic                             tape_we,
   output logic [$clog2(TAPE_DEPTH)-1:0]    tape_waddr,
   output logic [bie_pkg::BYTE_WIDTH-1:0]   tape_wdata,
   output logic                             tape_re,
   output logic [$clog2(TAPE_DEPTH)-1:0]    tape_raddr,
   input  logic [bie_pkg::BYTE_WIDTH-1:0]   tape_rdata,
   output logic                             stk_we,
   output logic [$clog2(STACK_DEPTH)-1:0]   stk_waddr,
   output logic [$clog2(PROGRAM_DEPTH)-1:0] stk_wdata,
   output logic                             stk_re,
   output logic [$clog2(STACK_DEPTH)-1:0]   stk_raddr,
   input  logic [$clog2(PROGRAM_DEPTH)-1:0] stk_rdata
);
   import bie_pkg::*;

   localparam int PAW       = $clog2(PROGRAM_DEPTH);
   localparam int PCW       = $clog2(PROGRAM_DEPTH + 1);
   localparam int TAW       = $clog2(TAPE_DEPTH);
   localparam int SAW       = $clog2(STACK_DEPTH);
   localparam int SDW       = $clog2(STACK_DEPTH + 1);
   localparam int CLR_DEPTH = (PROGRAM_DEPTH > TAPE_DEPTH) ? PROGRAM_DEPTH : TAPE_DEPTH;
   localparam int CW        = $clog2(CLR_DEPTH);
   localparam int CW1       = CW + 1;
   localparam int LW        = (ADDR_WIDTH > PCW) ? ADDR_WIDTH : PCW;

   fsm_state_type           state_ff, state_in;
   logic [PCW-1:0]          pc_ff, pc_in;
   logic [TAW-1:0]          tp_ff, tp_in;
   logic [SDW-1:0]          sd_ff, sd_in;
   logic [SDW-1:0]          skip_ff, skip_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [CW-1:0]           clr_ff, clr_in;
   logic                    clear_prog_ff, clear_prog_in;
   logic [ADDR_WIDTH-1:0]   addr_ff, addr_in;
   logic [BYTE_WIDTH-1:0]   data_ff, data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_item_ff, rsp_item_in;

   logic           accept;
   logic           addr_high;
   logic           clr_done;
   logic           emit;
   logic           char_emit;
   logic           do_adv;
   logic [PCW-1:0] adv_base;
   logic [PCW-1:0] adv_pc;
   logic           adv_end;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && (state_ff == S_IDLE);
   assign addr_high = LW'(addr_ff) >= LW'(PROGRAM_DEPTH);
   assign clr_done  = clear_prog_ff ? (clr_ff == CW'(CLR_DEPTH - 1))
                                    : (clr_ff == CW'(TAPE_DEPTH - 1));

   // Every item issues the three reads; only a step item uses the data.
   assign prog_re    = accept;
   assign prog_raddr = PAW'(pc_ff);
   assign tape_re    = accept;
   assign tape_raddr = tp_ff;
   assign stk_re     = accept;
   assign stk_raddr  = SAW'(sd_ff - 1'b1);

   assign adv_pc  = adv_base + 1'b1;
   assign adv_end = adv_pc >= PCW'(PROGRAM_DEPTH);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_item.operation)
                  OP_LOAD:  state_in = S_LOAD;
                  OP_START: state_in = S_CLEAR;
                  OP_STEP:  state_in = (status_ff == STAT_RUN) ? S_EXEC : S_IDLE;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            if (!addr_high) begin
               state_in = S_IDLE;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      pc_in         = pc_ff;
      tp_in         = tp_ff;
      sd_in         = sd_ff;
      skip_in       = skip_ff;
      status_in     = status_ff;
      clr_in        = clr_ff;
      clear_prog_in = clear_prog_ff;
      addr_in       = addr_ff;
      data_in       = data_ff;
      emit          = 1'b0;
      char_emit     = 1'b0;
      do_adv        = 1'b0;
      adv_base      = pc_ff;
      prog_we       = 1'b0;
      prog_waddr    = PAW'(addr_ff);
      prog_wdata    = data_ff;
      tape_we       = 1'b0;
      tape_waddr    = tp_ff;
      tape_wdata    = tape_rdata;
      stk_we        = 1'b0;
      stk_waddr     = SAW'(sd_ff);
      stk_wdata     = PAW'(pc_ff);

      case (state_ff)
         S_CLEAR: begin
            prog_we    = clear_prog_ff && (CW1'(clr_ff) < CW1'(PROGRAM_DEPTH));
            prog_waddr = PAW'(clr_ff);
            prog_wdata = '0;
            tape_we    = CW1'(clr_ff) < CW1'(TAPE_DEPTH);
            tape_waddr = TAW'(clr_ff);
            tape_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            // A start item reports once the tape is clean; the reset sweep does not.
            emit       = clr_done && !clear_prog_ff;
         end
         S_IDLE: begin
            if (accept) begin
               addr_in = req_item.address;
               data_in = req_item.data;
               case (req_item.operation)
                  OP_LOAD: begin
                  end
                  OP_START: begin
                     pc_in         = '0;
                     tp_in         = '0;
                     sd_in         = '0;
                     skip_in       = '0;
                     status_in     = STAT_RUN;
                     clr_in        = '0;
                     clear_prog_in = 1'b0;
                  end
                  OP_STEP: begin
                     emit = (status_ff != STAT_RUN);
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         S_LOAD: begin
            // Fold the load address into the program store one depth at a time.
            if (addr_high) begin
               addr_in = addr_ff - ADDR_WIDTH'(PROGRAM_DEPTH);
            end else begin
               prog_we = 1'b1;
               emit    = 1'b1;
            end
         end
         S_EXEC: begin
            emit = 1'b1;
            if (pc_ff >= PCW'(PROGRAM_DEPTH)) begin
               status_in = STAT_END;
            end else if (prog_rdata == CH_NUL) begin
               status_in = STAT_END;
            end else if (skip_ff != '0) begin
               case (prog_rdata)
                  CH_LBR: begin
                     if (skip_ff >= SDW'(STACK_DEPTH)) begin
                        status_in = STAT_OVERFLOW;
                     end else begin
                        skip_in = skip_ff + 1'b1;
                        do_adv  = 1'b1;
                     end
                  end
                  CH_RBR: begin
                     skip_in = skip_ff - 1'b1;
                     do_adv  = 1'b1;
                  end
                  default: begin
                     do_adv = 1'b1;
                  end
               endcase
            end else begin
               do_adv = 1'b1;
               case (prog_rdata)
                  CH_PLUS: begin
                     tape_we    = 1'b1;
                     tape_wdata = tape_rdata + 1'b1;
                  end
                  CH_MINUS: begin
                     tape_we    = 1'b1;
                     tape_wdata = tape_rdata - 1'b1;
                  end
                  CH_DOT: begin
                     char_emit = 1'b1;
                  end
                  CH_COMMA: begin
                     tape_we    = 1'b1;
                     tape_wdata = data_ff;
                  end
                  CH_GT: begin
                     tp_in = (tp_ff == TAW'(TAPE_DEPTH - 1)) ? '0 : tp_ff + 1'b1;
                  end
                  CH_LT: begin
                     tp_in = (tp_ff == '0) ? TAW'(TAPE_DEPTH - 1) : tp_ff - 1'b1;
                  end
                  CH_LBR: begin
                     if (tape_rdata == '0) begin
                        skip_in = SDW'(1);
                     end else if (sd_ff >= SDW'(STACK_DEPTH)) begin
                        status_in = STAT_OVERFLOW;
                        do_adv    = 1'b0;
                     end else begin
                        stk_we = 1'b1;
                        sd_in  = sd_ff + 1'b1;
                     end
                  end
                  CH_RBR: begin
                     if (sd_ff == '0) begin
                        status_in = STAT_UNMATCHED;
                        do_adv    = 1'b0;
                     end else if (tape_rdata != '0) begin
                        // Loop back to the instruction after the matching open bracket.
                        adv_base = PCW'(stk_rdata);
                     end else begin
                        sd_in = sd_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (do_adv) begin
               pc_in = adv_pc;
               if (adv_end) begin
                  status_in = STAT_END;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in                = emit;
      rsp_item_in.char_valid      = char_emit;
      rsp_item_in.char_out        = char_emit ? tape_rdata : '0;
      rsp_item_in.status          = status_in;
      rsp_item_in.program_counter = ADDR_WIDTH'(pc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         pc_ff         <= '0;
         tp_ff         <= '0;
         sd_ff         <= '0;
         skip_ff       <= '0;
         status_ff     <= STAT_RUN;
         clr_ff        <= '0;
         clear_prog_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         tp_ff         <= tp_in;
         sd_ff         <= sd_in;
         skip_ff       <= skip_in;
         status_ff     <= status_in;
         clr_ff        <= clr_in;
         clear_prog_ff <= clear_prog_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      data_ff     <= data_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- sv/brainfuck_instruction_engine.sv -----
// Brainfuck instruction engine: sequencer with program store, tape and loop stack memories.
// An item is taken when start is high and busy is low, and every item returns exactly one
// result, strobed by rsp_valid for a single cycle; the receiver cannot stall it. A step item
// first does the synchronous reads of the program store, the tape cell and the loop stack
// top, then executes and writes back. A load item writes the byte once its address has been
// folded back below PROGRAM_DEPTH. A step while halted and the unused operation answer
// straight from idle. A start item sweeps the tape clean one cell a cycle. After reset the
// block stays busy while it clears the program store and the tape.
module brainfuck_instruction_engine #(
   parameter int PROGRAM_DEPTH = bie_pkg::DEF_PROGRAM_DEPTH,
   parameter int TAPE_DEPTH    = bie_pkg::DEF_TAPE_DEPTH,
   parameter int STACK_DEPTH   = bie_pkg::DEF_STACK_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bie_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output bie_pkg::rsp_item_type rsp_item
);
   import bie_pkg::*;

   localparam int PAW = $clog2(PROGRAM_DEPTH);
   localparam int TAW = $clog2(TAPE_DEPTH);
   localparam int SAW = $clog2(STACK_DEPTH);

   logic                  prog_we, prog_re;
   logic [PAW-1:0]        prog_waddr, prog_raddr;
   logic [BYTE_WIDTH-1:0] prog_wdata, prog_rdata;
   logic                  tape_we, tape_re;
   logic [TAW-1:0]        tape_waddr, tape_raddr;
   logic [BYTE_WIDTH-1:0] tape_wdata, tape_rdata;
   logic                  stk_we, stk_re;
   logic [SAW-1:0]        stk_waddr, stk_raddr;
   logic [PAW-1:0]        stk_wdata, stk_rdata;

   bie_ram #(
      .DEPTH (PROGRAM_DEPTH),
      .WIDTH (BYTE_WIDTH)
   ) u_prog_store (
      .clock (clock),
      .we    (prog_we),
      .waddr (prog_waddr),
      .wdata (prog_wdata),
      .re    (prog_re),
      .raddr (prog_raddr),
      .rdata (prog_rdata)
   );

   bie_ram #(
      .DEPTH (TAPE_DEPTH),
      .WIDTH (BYTE_WIDTH)
   ) u_tape (
      .clock (clock),
      .we    (tape_we),
      .waddr (tape_waddr),
      .wdata (tape_wdata),
      .re    (tape_re),
      .raddr (tape_raddr),
      .rdata (tape_rdata)
   );

   bie_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (PAW)
   ) u_loop_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   bie_engine #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH),
      .TAPE_DEPTH    (TAPE_DEPTH),
      .STACK_DEPTH   (STACK_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .prog_we    (prog_we),
      .prog_waddr (prog_waddr),
      .prog_wdata (prog_wdata),
      .prog_re    (prog_re),
      .prog_raddr (prog_raddr),
      .prog_rdata (prog_rdata),
      .tape_we    (tape_we),
      .tape_waddr (tape_waddr),
      .tape_wdata (tape_wdata),
      .tape_re    (tape_re),
      .tape_raddr (tape_raddr),
      .tape_rdata (tape_rdata),
      .stk_we     (stk_we),
      .stk_waddr  (stk_waddr),
      .stk_wdata  (stk_wdata),
      .stk_re     (stk_re),
      .stk_raddr  (stk_raddr),
      .stk_rdata  (stk_rdata)
   );

endmodule
